[rtl/core/stp_pkg.sv]
// Shared types and constants for the string-to-unsigned parser.
// No dependencies; every other file imports this package.
package stp_pkg;

    localparam int VALUE_W  = 32;
    localparam int BASE_W   = 6;
    localparam int CH_W     = 8;
    localparam int DIGIT_W  = 6;
    localparam int OFFSET_W = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from the word address bit
    localparam logic [0:0] REG_NUMBER_BASE = 1'b0;

    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CH_W-1:0] CH_LX    = 8'h78;

    localparam logic [CH_W-1:0] UPPER_OFS = CH_UA - 8'd10;
    localparam logic [CH_W-1:0] LOWER_OFS = CH_LA - 8'd10;

    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

    localparam logic [VALUE_W-1:0]  VALUE_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic                overflow;
        logic                any_digits;
        logic [OFFSET_W-1:0] end_offset;
    } t_result;

    typedef struct packed {
        logic               below_base;
        logic               hex_digit;
        logic               carry;
        logic [VALUE_W-1:0] sum;
    } t_mac;

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
    endfunction

endpackage

[rtl/core/stp_if.sv]
// Handshake channels of the parser: character items in, result items out.
// Depends on stp_pkg.
interface stp_char_if import stp_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            first;

    modport source (output valid, ch, first, input ready);
    modport sink   (input valid, ch, first, output ready);
endinterface

interface stp_result_if import stp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  value;
    logic                overflow;
    logic                any_digits;
    logic [OFFSET_W-1:0] end_offset;

    modport source (output valid, value, overflow, any_digits, end_offset, input ready);
    modport sink   (input valid, value, overflow, any_digits, end_offset, output ready);
endinterface

[rtl/core/string_to_unsigned_parser.sv]
// Top level of the string-to-unsigned parser: input register, config regs, parse core.
// Depends on stp_pkg, stp_if, stp_cfg_regs, stp_parse_core.
//
// Takes one character item per clock, but for the stall below, and produces one
// result item per string, strtoul style. An item is registered on entry; from the
// input register a single 32x6 multiply-add with carry check updates the parse
// state and, when the number ends, loads the result register, so a result passes
// the input register and then the result register; throughput is one character
// per cycle but for the stall below. The state loop through that multiply-add sets
// the rate. Input stalls only while a result waits untaken and the next character
// ends a number. number_base is sampled when a string's first character is
// processed; write it only while the block is idle.
module string_to_unsigned_parser import stp_pkg::*; #(
    parameter longint unsigned POSITION_LIMIT = 65535
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    stp_char_if.sink              i_in,
    stp_result_if.source          o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic              r_in_valid;
    logic [CH_W-1:0]   r_in_ch;
    logic              r_in_first;
    logic              advance;
    logic [BASE_W-1:0] number_base;
    t_result           result;

    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
            r_in_ch    <= i_in.ch;
            r_in_first <= i_in.first;
        end
    end

    stp_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_number_base (number_base)
    );

    stp_parse_core #(
        .POSITION_LIMIT (POSITION_LIMIT)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_in_valid),
        .i_ch          (r_in_ch),
        .i_first       (r_in_first),
        .i_number_base (number_base),
        .i_out_ready   (o_out.ready),
        .o_advance     (advance),
        .o_out_valid   (o_out.valid),
        .o_result      (result)
    );

    assign o_out.value      = result.value;
    assign o_out.overflow   = result.overflow;
    assign o_out.any_digits = result.any_digits;
    assign o_out.end_offset = result.end_offset;

endmodule

[rtl/core/stp_cfg_regs.sv]
// APB-style register file holding number_base.
// Depends on stp_pkg.
module stp_cfg_regs import stp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [BASE_W-1:0]     o_number_base
);

    logic [BASE_W-1:0] r_number_base;
    logic              wr_base;

    assign pready  = 1'b1;
    assign wr_base = psel && penable && pwrite && (paddr[2] == REG_NUMBER_BASE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BASE_RESET;
        end else if (wr_base) begin
            r_number_base <= pwdata[BASE_W-1:0];
        end
    end

    assign prdata        = (paddr[2] == REG_NUMBER_BASE) ? APB_DATA_W'(r_number_base) : '0;
    assign o_number_base = r_number_base;

endmodule

[rtl/core/stp_digit_mac.sv]
// Digit decode and accumulate: acc * base + digit with 32-bit carry-out.
// Depends on stp_pkg.
module stp_digit_mac import stp_pkg::*; (
    input  logic [CH_W-1:0]    i_ch,
    input  logic [BASE_W-1:0]  i_base,
    input  logic [VALUE_W-1:0] i_acc,
    output t_mac               o_mac
);

    localparam int PROD_W = VALUE_W + BASE_W;

    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W:0]    full;

    always_comb begin
        is_digit = 1'b1;
        digit    = '0;
        if (i_ch >= CH_0 && i_ch <= CH_9) begin
            digit = DIGIT_W'(i_ch - CH_0);
        end else if (i_ch >= CH_UA && i_ch <= CH_UZ) begin
            digit = DIGIT_W'(i_ch - UPPER_OFS);
        end else if (i_ch >= CH_LA && i_ch <= CH_LZ) begin
            digit = DIGIT_W'(i_ch - LOWER_OFS);
        end else begin
            is_digit = 1'b0;
        end
    end

    assign prod = PROD_W'(i_acc) * PROD_W'(i_base);
    assign full = (PROD_W + 1)'(prod) + (PROD_W + 1)'(digit);

    assign o_mac.below_base = is_digit && (digit < i_base);
    assign o_mac.hex_digit  = is_digit && (digit < BASE_HEX);
    assign o_mac.carry      = |full[PROD_W:VALUE_W];
    assign o_mac.sum        = full[VALUE_W-1:0];

endmodule

[rtl/core/stp_parse_core.sv]
// Parse FSM: one character per cycle, if o_advance, updates the parse state and
// loads the result register when a number ends. Depends on stp_pkg, stp_digit_mac.
module stp_parse_core import stp_pkg::*; #(
    parameter longint unsigned POSITION_LIMIT = 65535
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [CH_W-1:0]   i_ch,
    input  logic              i_first,
    input  logic [BASE_W-1:0] i_number_base,
    input  logic              i_out_ready,
    output logic              o_advance,
    output logic              o_out_valid,
    output t_result           o_result
);

    localparam int POS_W = $clog2(POSITION_LIMIT + 64'd1);

    typedef enum logic [2:0] {
        PH_IDLE, PH_LEAD, PH_SIGNED, PH_ZERO, PH_HEXPFX, PH_DIGITS, PH_DONE
    } t_phase;

    t_phase             r_phase, n_phase, cur_phase;
    logic               r_neg, n_neg, cur_neg;
    logic [BASE_W-1:0]  r_base, n_base, cur_base, eff_base;
    logic [VALUE_W-1:0] r_acc, n_acc, cur_acc;
    logic               r_ovf, n_ovf, cur_ovf;
    logic               r_seen, n_seen, cur_seen;
    logic [POS_W-1:0]   r_pos, n_pos, cur_pos, end_pos;
    logic               r_out_valid;
    t_result            r_out, n_out;

    logic               bad_radix, emit, take, lead_digit, skip;
    logic [63:0]        end_ext;
    t_mac               mac;

    // only a character that ends a number has to wait for the result register
    assign o_advance = i_valid && (!emit || !r_out_valid || i_out_ready);

    always_comb begin
        if (i_first) begin
            cur_phase = PH_LEAD;
            cur_neg   = 1'b0;
            cur_base  = i_number_base;
            cur_acc   = '0;
            cur_ovf   = 1'b0;
            cur_seen  = 1'b0;
            cur_pos   = '0;
        end else begin
            cur_phase = r_phase;
            cur_neg   = r_neg;
            cur_base  = r_base;
            cur_acc   = r_acc;
            cur_ovf   = r_ovf;
            cur_seen  = r_seen;
            cur_pos   = r_pos;
        end
    end

    // auto base resolves to octal after a leading zero, decimal otherwise
    always_comb begin
        if (cur_base == BASE_AUTO) begin
            eff_base = (cur_phase == PH_ZERO) ? BASE_OCT : BASE_DEC;
        end else begin
            eff_base = cur_base;
        end
    end

    stp_digit_mac u_mac (
        .i_ch   (i_ch),
        .i_base (eff_base),
        .i_acc  (cur_acc),
        .o_mac  (mac)
    );

    always_comb begin
        n_phase    = cur_phase;
        n_neg      = cur_neg;
        n_base     = cur_base;
        n_acc      = cur_acc;
        n_ovf      = cur_ovf;
        n_seen     = cur_seen;
        n_pos      = cur_pos;
        emit       = 1'b0;
        take       = 1'b0;
        lead_digit = 1'b0;
        skip       = 1'b0;
        end_pos    = cur_pos;
        bad_radix  = i_first && (i_number_base == BASE_ONE || i_number_base > BASE_MAX);

        if (bad_radix) begin
            emit    = 1'b1;
            end_pos = '0;
        end else begin
            case (cur_phase)
                PH_LEAD: begin
                    if (is_space(i_ch)) begin
                        n_phase = PH_LEAD;
                    end else if (i_ch == CH_PLUS || i_ch == CH_MINUS) begin
                        n_neg   = (i_ch == CH_MINUS);
                        n_phase = PH_SIGNED;
                    end else begin
                        lead_digit = 1'b1;
                    end
                end
                PH_SIGNED: lead_digit = 1'b1;
                PH_ZERO: begin
                    if (i_ch == CH_LX || i_ch == CH_UX) begin
                        n_base  = BASE_HEX;
                        n_phase = PH_HEXPFX;
                    end else begin
                        n_base = eff_base;
                        take   = 1'b1;
                    end
                end
                PH_HEXPFX: begin
                    if (mac.hex_digit) begin
                        take = 1'b1;
                    end else begin
                        // "0x" with no hex digit: number ends at the x
                        emit    = 1'b1;
                        end_pos = (cur_pos != '0) ? POS_W'(cur_pos - 1'b1) : '0;
                    end
                end
                PH_DIGITS: take = 1'b1;
                default:   skip = 1'b1;
            endcase
        end

        if (lead_digit) begin
            if (i_ch == CH_0 && (cur_base == BASE_AUTO || cur_base == BASE_HEX)) begin
                n_seen  = 1'b1;
                n_phase = PH_ZERO;
            end else begin
                n_base = eff_base;
                take   = 1'b1;
            end
        end

        if (take) begin
            if (!mac.below_base) begin
                emit    = 1'b1;
                end_pos = cur_pos;
            end else begin
                n_seen  = 1'b1;
                n_phase = PH_DIGITS;
                if (!cur_ovf) begin
                    if (mac.carry) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = mac.sum;
                    end
                end
            end
        end

        if (emit) begin
            n_phase = PH_DONE;
        end

        if (!bad_radix && !skip && (64'(cur_pos) < POSITION_LIMIT)) begin
            n_pos = POS_W'(cur_pos + 1'b1);
        end
    end

    always_comb begin
        end_ext = 64'(end_pos);
        if (cur_ovf) begin
            n_out.value = VALUE_ALL_ONES;
        end else if (cur_neg) begin
            n_out.value = VALUE_W'(0) - cur_acc;
        end else begin
            n_out.value = cur_acc;
        end
        n_out.overflow   = cur_ovf;
        n_out.any_digits = cur_seen;
        if (!cur_seen) begin
            n_out.end_offset = '0;
        end else if (end_ext > 64'(OFFSET_MAX)) begin
            n_out.end_offset = OFFSET_MAX;
        end else begin
            n_out.end_offset = end_ext[OFFSET_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_neg       <= 1'b0;
            r_base      <= '0;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_seen      <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_base  <= n_base;
                r_acc   <= n_acc;
                r_ovf   <= n_ovf;
                r_seen  <= n_seen;
                r_pos   <= n_pos;
            end
            if (o_advance && emit) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    a_ovf_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.overflow |-> r_out.value == VALUE_ALL_ONES)
        else $error("overflow result not saturated");

    a_nodig_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.any_digits |-> r_out.end_offset == '0 && !r_out.overflow)
        else $error("result without digits has offset or overflow");

    a_ovf_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_seen)
        else $error("overflow flagged without a digit");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_advance && emit |=> r_phase == PH_DONE && r_out_valid)
        else $error("ended number did not close the string");

endmodule
